[hdl/sfc_pkg.sv]
package sfc_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CfgAddrWidth = 2;
  localparam logic [CfgAddrWidth-1:0] CFG_START_MARKER    = 2'd0;
  localparam logic [CfgAddrWidth-1:0] CFG_END_MARKER      = 2'd1;
  localparam logic [CfgAddrWidth-1:0] CFG_MAX_BODY_LENGTH = 2'd2;

  localparam logic [15:0] MaxBodyLengthReset = 16'hFFFF;
  localparam logic [15:0] MinBodyLength      = 16'd2;

  // Frame status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CHECK_ERR = 2'd1,
    STATUS_END_ERR   = 2'd2,
    STATUS_LEN_ERR   = 2'd3
  } status_e;

  // Receiver phases.
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  // Live configuration values.
  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [15:0] max_body_length;
  } sfc_cfg_t;

  // One frame status report.
  typedef struct packed {
    status_e     status;
    logic [15:0] body_length;
    logic [7:0]  received_check;
    logic [7:0]  computed_check;
  } sfc_result_t;

endpackage

[hdl/sfc_cfg_regs.sv]
module sfc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfc_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [15:0]                       cfg_data_i,
  output sfc_pkg::sfc_cfg_t                 cfg_o
);

  sfc_pkg::sfc_cfg_t cfg_q, cfg_d;

  // Decode the register index; indexes past the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        sfc_pkg::CFG_START_MARKER:    cfg_d.start_marker    = cfg_data_i[7:0];
        sfc_pkg::CFG_END_MARKER:      cfg_d.end_marker      = cfg_data_i[7:0];
        sfc_pkg::CFG_MAX_BODY_LENGTH: cfg_d.max_body_length = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker    <= 8'h00;
      cfg_q.end_marker      <= 8'h00;
      cfg_q.max_body_length <= sfc_pkg::MaxBodyLengthReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/sfc_parser.sv]
module sfc_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_accept_i,
  input  logic [7:0]            rx_byte_i,
  input  sfc_pkg::sfc_cfg_t     cfg_i,
  output logic                  res_valid_o,
  output sfc_pkg::sfc_result_t  res_o
);

  sfc_pkg::phase_e phase_q, phase_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  running_xor_q, running_xor_d;
  logic [7:0]  check_found_q, check_found_d;
  logic        check_ok_q, check_ok_d;

  logic [15:0] full_length;
  logic [7:0]  computed;
  logic        len_bad;

  assign full_length = {frame_length_q[15:8], rx_byte_i};
  assign computed    = ~running_xor_q;
  assign len_bad     = (full_length < sfc_pkg::MinBodyLength) ||
                       (full_length > cfg_i.max_body_length);

  // Next state and result for the byte being accepted.
  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    bytes_left_d   = bytes_left_q;
    running_xor_d  = running_xor_q;
    check_found_d  = check_found_q;
    check_ok_d     = check_ok_q;
    res_valid_o    = 1'b0;
    res_o.status         = sfc_pkg::STATUS_OK;
    res_o.body_length    = frame_length_q;
    res_o.received_check = check_found_q;
    res_o.computed_check = computed;

    if (in_accept_i) begin
      case (phase_q)
        sfc_pkg::PH_LEN_HI: begin
          frame_length_d = {rx_byte_i, 8'h00};
          running_xor_d  = running_xor_q ^ rx_byte_i;
          phase_d        = sfc_pkg::PH_LEN_LO;
        end
        sfc_pkg::PH_LEN_LO: begin
          frame_length_d = full_length;
          running_xor_d  = running_xor_q ^ rx_byte_i;
          if (len_bad) begin
            phase_d              = sfc_pkg::PH_HUNT;
            res_valid_o          = 1'b1;
            res_o.status         = sfc_pkg::STATUS_LEN_ERR;
            res_o.body_length    = full_length;
            res_o.received_check = 8'h00;
            res_o.computed_check = 8'h00;
          end else begin
            bytes_left_d = full_length;
            phase_d      = sfc_pkg::PH_BODY;
          end
        end
        sfc_pkg::PH_BODY: begin
          if (bytes_left_q > 16'd2) begin
            running_xor_d = running_xor_q ^ rx_byte_i;
            bytes_left_d  = bytes_left_q - 16'd1;
          end else if (bytes_left_q == 16'd2) begin
            // Check byte: it is not folded into the running XOR.
            check_found_d = rx_byte_i;
            check_ok_d    = (rx_byte_i == computed);
            bytes_left_d  = 16'd1;
          end else begin
            // End marker byte closes the frame; the check byte wins ties.
            bytes_left_d = 16'd0;
            phase_d      = sfc_pkg::PH_HUNT;
            res_valid_o  = 1'b1;
            if (!check_ok_q) begin
              res_o.status = sfc_pkg::STATUS_CHECK_ERR;
            end else if (rx_byte_i != cfg_i.end_marker) begin
              res_o.status = sfc_pkg::STATUS_END_ERR;
            end else begin
              res_o.status = sfc_pkg::STATUS_OK;
            end
          end
        end
        default: begin
          if (rx_byte_i == cfg_i.start_marker) begin
            running_xor_d  = rx_byte_i;
            frame_length_d = 16'd0;
            bytes_left_d   = 16'd0;
            check_found_d  = 8'h00;
            check_ok_d     = 1'b0;
            phase_d        = sfc_pkg::PH_LEN_HI;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= sfc_pkg::PH_HUNT;
      frame_length_q <= 16'd0;
      bytes_left_q   <= 16'd0;
      running_xor_q  <= 8'h00;
      check_found_q  <= 8'h00;
      check_ok_q     <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      bytes_left_q   <= bytes_left_d;
      running_xor_q  <= running_xor_d;
      check_found_q  <= check_found_d;
      check_ok_q     <= check_ok_d;
    end
  end

`ifndef SYNTHESIS
  // Inside a body the byte count never runs out or exceeds the length field.
  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sfc_pkg::PH_BODY) |->
      (bytes_left_q != 16'd0) && (bytes_left_q <= frame_length_q))
    else $error("body byte count out of range");

  // A good status means the check byte matched.
  a_ok_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == sfc_pkg::STATUS_OK) |->
      (res_o.received_check == res_o.computed_check))
    else $error("ok status with mismatching check byte");

  // A length error reports a length outside the allowed window.
  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == sfc_pkg::STATUS_LEN_ERR) |->
      ((res_o.body_length < sfc_pkg::MinBodyLength) ||
       (res_o.body_length > cfg_i.max_body_length)))
    else $error("length error with legal length");

  // Every report sends the receiver back to hunting.
  a_report_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (phase_q == sfc_pkg::PH_HUNT))
    else $error("receiver not hunting after a report");
`endif

endmodule

[hdl/sfc_out_reg.sv]
module sfc_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  input  sfc_pkg::sfc_result_t  res_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  slot_free_o,
  output sfc_pkg::sfc_result_t  out_o
);

  logic                 valid_q, valid_d;
  sfc_pkg::sfc_result_t data_q;

  // The slot can take a new result when empty or being drained this cycle.
  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

[hdl/serial_frame_checker.sv]
// A status request appears on the master side in the cycle after the byte
// that ends its frame (or the low length byte, on a length error).
// Throughput: one received byte per cycle, set by the single output register;
// bytes stall only while a finished status waits on the master side.
// Reset: asynchronous, active low; the receiver hunts for a start marker and
// the markers reset to 0 and the maximum body length to 65535.
module serial_frame_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [sfc_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [15:0]                       cfg_data_i,
  // Received bytes.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  // Frame status.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] body_length, [23:16] received_check, [31:24] computed_check
  output logic [31:0]                       m_axis_tdata,
  output logic [1:0]                        m_axis_tuser    // [1:0] status
);

  sfc_pkg::sfc_cfg_t    cfg;
  sfc_pkg::sfc_result_t res;
  sfc_pkg::sfc_result_t out_res;
  logic                 res_valid;
  logic                 slot_free;
  logic                 in_accept;

  assign s_axis_tready = slot_free;
  assign in_accept     = s_axis_tvalid && slot_free;

  sfc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .rx_byte_i   (s_axis_tdata),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .slot_free_o (slot_free),
    .out_o       (out_res)
  );

  // Pack the status request onto the master side.
  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {out_res.computed_check, out_res.received_check,
                         out_res.body_length};

endmodule
